[design/lsra_pkg.sv]
// shared constants and types for the linear scan register allocator
package lsra_pkg;

  localparam int PHYS_REGS = 256;
  localparam int VIRT_REGS = 1024;
  localparam int POS_BITS  = 16;
  localparam int PREG_W    = $clog2(PHYS_REGS);
  localparam int VREG_W    = 10;
  localparam int MAP_AW    = $clog2(VIRT_REGS);
  localparam int THR_W     = 9;
  localparam int GRP_SIZE  = 16;
  localparam int GRP_N     = PHYS_REGS / GRP_SIZE;
  localparam int GRP_W     = $clog2(GRP_SIZE);
  localparam int GSEL_W    = $clog2(GRP_N);

  typedef struct packed {
    logic              load;
    logic              cmp;
    logic              grp;
    logic              sel;
    logic              clr_we;
    logic              busy_clr;
    logic              zero_out;
    logic [MAP_AW-1:0] clr_addr;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

endpackage

[design/linear_scan_register_allocator.sv]
// An interval passes through these steps before its result appears: the hint
// map read at the transfer edge, a parallel compare of all 256 busy marks
// against the start, a per-group first-free search over 16 groups of 16, and
// the final pick and write-back. No new interval is taken until the previous
// one is written back; a stalled result holds the pick step until it drains.
// A clear command runs a sweep over all 1024 entries of the register map
// memory, and its all-zero result follows the sweep; the same sweep runs
// after reset, with input stalled during the sweep. The byte threshold may be
// written at any time the block is idle.
module linear_scan_register_allocator import lsra_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [THR_W-1:0]    cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                command,
  input  logic [VREG_W-1:0]   vreg,
  input  logic [POS_BITS-1:0] live_start,
  input  logic [POS_BITS-1:0] live_end,
  input  logic                fixed,
  input  logic                has_hint,
  input  logic [VREG_W-1:0]   hint_vreg,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [VREG_W-1:0]   phys_reg,
  output logic                used_fallback,
  output logic                took_hint
);

  cmd_t  cmd;
  stat_t stat;

  lsra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lsra_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .vreg          (vreg),
    .live_start    (live_start),
    .live_end      (live_end),
    .fixed         (fixed),
    .has_hint      (has_hint),
    .hint_vreg     (hint_vreg),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .phys_reg      (phys_reg),
    .used_fallback (used_fallback),
    .took_hint     (took_hint)
  );

endmodule

[design/lsra_ctrl.sv]
// controller state machine for the register allocator
module lsra_ctrl import lsra_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  command,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [2:0] S_RCLR  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_GRP   = 3'd3;
  localparam logic [2:0] S_SEL   = 3'd4;
  localparam logic [2:0] S_CLR   = 3'd5;
  localparam logic [2:0] S_CDONE = 3'd6;

  logic [2:0]        state, state_next;
  logic [MAP_AW-1:0] cnt;
  logic              cnt_last;

  assign cnt_last = (cnt == MAP_AW'(VIRT_REGS - 1));
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.clr_addr = cnt;
    unique case (state)
      S_RCLR: begin
        cmd.clr_we = 1'b1;
        if (cnt_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (command) begin
            cmd.busy_clr = 1'b1;
            state_next   = S_CLR;
          end else begin
            state_next = S_CMP;
          end
        end
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = S_GRP;
      end
      S_GRP: begin
        cmd.grp    = 1'b1;
        state_next = S_SEL;
      end
      S_SEL: begin
        if (!stat.out_busy) begin
          cmd.sel    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CLR: begin
        cmd.clr_we = 1'b1;
        if (cnt_last) state_next = S_CDONE;
      end
      S_CDONE: begin
        if (!stat.out_busy) begin
          cmd.zero_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RCLR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (cmd.clr_we) cnt <= cnt + 1'b1;
    end
  end

endmodule

[design/lsra_dp.sv]
// datapath: busy marks, register map memory, free search and result register
module lsra_dp import lsra_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic                cfg_we,
  input  logic [THR_W-1:0]    cfg_data,
  input  logic [VREG_W-1:0]   vreg,
  input  logic [POS_BITS-1:0] live_start,
  input  logic [POS_BITS-1:0] live_end,
  input  logic                fixed,
  input  logic                has_hint,
  input  logic [VREG_W-1:0]   hint_vreg,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [VREG_W-1:0]   phys_reg,
  output logic                used_fallback,
  output logic                took_hint
);

  logic [THR_W-1:0]    thr;
  logic [THR_W-1:0]    thr_eff;
  logic [VREG_W-1:0]   vreg_q;
  logic [POS_BITS-1:0] start_q, end_q;
  logic                fixed_q, hint_en_q;

  logic [VREG_W:0]     map_mem [VIRT_REGS];
  logic [VREG_W:0]     map_rd;
  logic                map_we;
  logic [MAP_AW-1:0]   map_wa;
  logic [VREG_W:0]     map_wd;

  logic [POS_BITS-1:0] mark [PHYS_REGS];
  logic [PHYS_REGS-1:0] mvld;

  logic [PHYS_REGS-1:0] free_now, free_q, lo_mask;
  logic                 hint_pre;
  logic [PREG_W-1:0]    hint_preg;
  logic                 hint_ok;

  logic [GRP_N-1:0]     lo_any, hi_any, lo_any_q, hi_any_q;
  logic [GRP_W-1:0]     lo_idx [GRP_N];
  logic [GRP_W-1:0]     hi_idx [GRP_N];
  logic [GRP_W-1:0]     lo_idx_q [GRP_N];
  logic [GRP_W-1:0]     hi_idx_q [GRP_N];

  logic                 sel_lo, sel_hi;
  logic [GSEL_W-1:0]    lo_g, hi_g;
  logic [PREG_W-1:0]    pick;
  logic                 fb;
  logic [PREG_W-1:0]    fix_r;
  logic                 fix_upd;

  assign thr_eff = (thr > THR_W'(PHYS_REGS)) ? THR_W'(PHYS_REGS) : thr;
  assign stat.out_busy = out_valid & out_stall;

  always_ff @(posedge clk) begin
    if (rst) thr <= THR_W'(16);
    else if (cfg_we) thr <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vreg_q    <= vreg;
      start_q   <= live_start;
      end_q     <= live_end;
      fixed_q   <= fixed;
      hint_en_q <= has_hint;
    end
  end

  // map memory, valid flag in the top bit
  always_comb begin
    map_we = 1'b0;
    map_wa = vreg_q;
    map_wd = {1'b1, VREG_W'(pick)};
    if (cmd.clr_we) begin
      map_we = 1'b1;
      map_wa = cmd.clr_addr;
      map_wd = '0;
    end else if (cmd.sel) begin
      map_we = 1'b1;
      if (fixed_q) map_wd = {1'b1, vreg_q};
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    if (cmd.load) map_rd <= map_mem[hint_vreg];
  end

  // free compare per register
  always_comb begin
    for (int i = 0; i < PHYS_REGS; i++) begin
      free_now[i] = !mvld[i] || (mark[i] <= start_q);
      lo_mask[i]  = (THR_W'(i) < thr_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      free_q    <= free_now;
      hint_pre  <= hint_en_q && map_rd[VREG_W] &&
                   (map_rd[VREG_W-1:0] < VREG_W'(thr_eff));
      hint_preg <= map_rd[PREG_W-1:0];
    end
  end

  // first free within each group
  always_comb begin
    for (int g = 0; g < GRP_N; g++) begin
      lo_any[g] = 1'b0;
      hi_any[g] = 1'b0;
      lo_idx[g] = '0;
      hi_idx[g] = '0;
      for (int b = GRP_SIZE - 1; b >= 0; b--) begin
        if (free_q[g*GRP_SIZE+b] && lo_mask[g*GRP_SIZE+b]) begin
          lo_any[g] = 1'b1;
          lo_idx[g] = GRP_W'(b);
        end
        if (free_q[g*GRP_SIZE+b] && !lo_mask[g*GRP_SIZE+b]) begin
          hi_any[g] = 1'b1;
          hi_idx[g] = GRP_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.grp) begin
      lo_any_q <= lo_any;
      hi_any_q <= hi_any;
      lo_idx_q <= lo_idx;
      hi_idx_q <= hi_idx;
      hint_ok  <= hint_pre && free_q[hint_preg];
    end
  end

  // first group with a free register
  always_comb begin
    sel_lo = 1'b0;
    sel_hi = 1'b0;
    lo_g   = '0;
    hi_g   = '0;
    for (int g = GRP_N - 1; g >= 0; g--) begin
      if (lo_any_q[g]) begin
        sel_lo = 1'b1;
        lo_g   = GSEL_W'(g);
      end
      if (hi_any_q[g]) begin
        sel_hi = 1'b1;
        hi_g   = GSEL_W'(g);
      end
    end
    fb = 1'b0;
    if (hint_ok) pick = hint_preg;
    else if (sel_lo) pick = {lo_g, lo_idx_q[lo_g]};
    else if (sel_hi) pick = {hi_g, hi_idx_q[hi_g]};
    else begin
      pick = '0;
      fb   = 1'b1;
    end
  end

  assign fix_r   = vreg_q[PREG_W-1:0];
  assign fix_upd = (vreg_q[VREG_W-1:PREG_W] == '0) &&
                   (!mvld[fix_r] || (mark[fix_r] < end_q));

  always_ff @(posedge clk) begin
    if (rst) begin
      mvld <= '0;
    end else if (cmd.busy_clr) begin
      mvld <= '0;
    end else if (cmd.sel) begin
      if (!fixed_q) mvld[pick] <= 1'b1;
      else if (fix_upd) mvld[fix_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sel) begin
      if (!fixed_q) mark[pick] <= end_q;
      else if (fix_upd) mark[fix_r] <= end_q;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.sel || cmd.zero_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.zero_out) begin
      phys_reg      <= '0;
      used_fallback <= 1'b0;
      took_hint     <= 1'b0;
    end else if (cmd.sel) begin
      phys_reg      <= fixed_q ? vreg_q : VREG_W'(pick);
      used_fallback <= !fixed_q && fb;
      took_hint     <= !fixed_q && hint_ok;
    end
  end

endmodule

[design/lsra_checker.sv]
// port-level checks for the register allocator
module lsra_checker import lsra_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [VREG_W-1:0] phys_reg,
  input logic              used_fallback,
  input logic              took_hint
);

  // one interval at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("transfer accepted while previous item in flight");

  a_reset_sweep: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input not stalled during map sweep");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(phys_reg)))
    else $error("stalled result changed");

  a_fallback_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && used_fallback) |-> (phys_reg == '0 && !took_hint))
    else $error("fallback result not register zero");

endmodule

bind linear_scan_register_allocator lsra_checker u_lsra_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .phys_reg      (phys_reg),
  .used_fallback (used_fallback),
  .took_hint     (took_hint)
);
